// ===== src/bdpc_pkg.sv =====
// bdpc_pkg: shared types and constants of the button debounce press classifier
// no dependencies; imported by every module of the block

package bdpc_pkg;

	localparam int unsigned DebounceW = 10;
	localparam int unsigned CountW    = 16;
	localparam int unsigned EventW    = 2;
	localparam int unsigned CfgIdxW   = 1;
	localparam int unsigned CfgDataW  = 16;

	// register indexes of the write port
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 1'd1;

	localparam logic [DebounceW-1:0] DEBOUNCE_RESET   = 10'd50;
	localparam logic [CountW-1:0]    LONG_PRESS_RESET = 16'd5000;
	localparam logic [CountW-1:0]    COUNT_MAX        = 16'hFFFF;

	// press event codes
	localparam logic [EventW-1:0] EV_NONE  = 2'd0;
	localparam logic [EventW-1:0] EV_SHORT = 2'd1;
	localparam logic [EventW-1:0] EV_LONG  = 2'd2;

	typedef struct packed {
		logic [DebounceW-1:0] debounce_ms;
		logic [CountW-1:0]    long_press_ms;
	} cfg_t;

	function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
		return (v == COUNT_MAX) ? v : v + CountW'(1);
	endfunction

endpackage

// ===== src/bdpc_cfg.sv =====
// bdpc_cfg: configuration registers written through the plain write port
// depends on bdpc_pkg

module bdpc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bdpc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bdpc_pkg::CfgDataW-1:0] cfg_data,
	output bdpc_pkg::cfg_t                cfg
);
	import bdpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RESET;
			cfg_q.long_press_ms <= LONG_PRESS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data[DebounceW-1:0];
				REG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data[CountW-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/bdpc_core.sv =====
// bdpc_core: debounce and press classification state with its one-tick step logic
// depends on bdpc_pkg

module bdpc_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step_en,
	input  logic                        level,
	input  bdpc_pkg::cfg_t              cfg,
	output logic [bdpc_pkg::EventW-1:0] press_event
);
	import bdpc_pkg::*;

	logic              prev_level_q;
	logic              stable_level_q;
	logic [CountW-1:0] since_change_q;
	logic              pressing_q;
	logic [CountW-1:0] press_ticks_q;
	logic              long_reported_q;

	logic              stable_level_d;
	logic [CountW-1:0] since_change_d;
	logic              pressing_d;
	logic [CountW-1:0] press_ticks_d;
	logic              long_reported_d;
	logic [EventW-1:0] event_d;
	logic              accept_level;

	always_comb begin
		press_ticks_d   = pressing_q ? sat_inc(press_ticks_q) : press_ticks_q;
		since_change_d  = (level != prev_level_q) ? '0 : sat_inc(since_change_q);
		stable_level_d  = stable_level_q;
		pressing_d      = pressing_q;
		long_reported_d = long_reported_q;
		event_d         = EV_NONE;
		accept_level    = (since_change_d > CountW'(cfg.debounce_ms))
			&& (level != stable_level_q);
		if (accept_level) begin
			stable_level_d = level;
			if (!level) begin
				pressing_d      = 1'b1;
				press_ticks_d   = '0;
				long_reported_d = 1'b0;
			end else begin
				pressing_d = 1'b0;
				if (!long_reported_q && (press_ticks_d > CountW'(cfg.debounce_ms))) begin
					event_d = EV_SHORT;
				end
			end
		end
		if (pressing_d && !long_reported_d && (press_ticks_d >= cfg.long_press_ms)) begin
			long_reported_d = 1'b1;
			event_d         = EV_LONG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q    <= 1'b1;
			stable_level_q  <= 1'b1;
			since_change_q  <= '0;
			pressing_q      <= 1'b0;
			press_ticks_q   <= '0;
			long_reported_q <= 1'b0;
		end else if (step_en) begin
			prev_level_q    <= level;
			stable_level_q  <= stable_level_d;
			since_change_q  <= since_change_d;
			pressing_q      <= pressing_d;
			press_ticks_q   <= press_ticks_d;
			long_reported_q <= long_reported_d;
		end
	end

	assign press_event = event_d;

	// a press in progress always has a stable low level behind it
	a_pressing_low: assert property (@(posedge clk) disable iff (!arst_n)
		pressing_q |-> !stable_level_q)
		else $error("pressing without stable low level");

	// a long press marks itself reported so it fires once
	a_long_once: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && (event_d == EV_LONG)) |=> (long_reported_q && pressing_q))
		else $error("long press not recorded");

	// a short press ends the press
	a_short_release: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && (event_d == EV_SHORT)) |=> (!pressing_q && stable_level_q))
		else $error("short press without release");

endmodule

// ===== src/button_debounce_press_classifier.sv =====
// button_debounce_press_classifier: top level with input register, result register and handshake
// depends on bdpc_pkg, bdpc_cfg and bdpc_core

// channel   | handshake                     | payload
// ----------+-------------------------------+----------------------------
// input     | in_valid / in_stall           | button_level  (1 bit)
// result    | out_valid / out_stall         | press_event   (2 bits)
// config    | cfg_we, cfg_index             | cfg_data      (16 bits)
//
// one request per clock sustained while the result is not stalled
// the input register feeds the step logic, which updates the state and loads the result register
// reset clears all state, brings both registers to empty and loads the default timings
// a stalled result holds the step; the input register then fills and in_stall rises

module button_debounce_press_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          button_level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bdpc_pkg::EventW-1:0]   press_event,
	input  logic                          cfg_we,
	input  logic [bdpc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bdpc_pkg::CfgDataW-1:0] cfg_data
);
	import bdpc_pkg::*;

	cfg_t              cfg;
	logic              valid_s1;
	logic              level_s1;
	logic              out_valid_q;
	logic [EventW-1:0] event_q;
	logic [EventW-1:0] step_event;
	logic              in_take;
	logic              advance;

	// the held request steps once the result slot is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	bdpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdpc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.level       (level_s1),
		.cfg         (cfg),
		.press_event (step_event)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			level_s1 <= button_level;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= step_event;
		end
	end

	assign out_valid   = out_valid_q;
	assign press_event = event_q;

	// back-pressure only comes from a full pipe with a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without full pipe");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for button_debounce_press_classifier, one tick per request
// depends on bdpc_pkg and the rtl top; predicts every press event and checks it in order

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bdpc_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 button_level = 1'b1;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [EventW-1:0]    press_event;
	logic                 cfg_we = 1'b0;
	logic [CfgIdxW-1:0]   cfg_index = REG_DEBOUNCE;
	logic [CfgDataW-1:0]  cfg_data = '0;

	button_debounce_press_classifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.press_event  (press_event),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// pending pin samples and the events they are predicted to cause
	logic                 tick_levels[$];
	logic [EventW-1:0]    expected_events[$];
	logic [EventW-1:0]    want_event;

	// our own copy of the timing registers, at their reset values
	logic [DebounceW-1:0] db_ticks = DEBOUNCE_RESET;
	logic [CountW-1:0]    long_ticks = LONG_PRESS_RESET;

	// our own copy of the debouncer and press-timer state
	logic                 prev_raw = 1'b1;
	logic                 stable_level = 1'b1;
	logic [CountW-1:0]    since_change = '0;
	logic                 pressing = 1'b0;
	logic [CountW-1:0]    press_ticks = '0;
	logic                 long_done = 1'b0;

	logic                 no_idle = 1'b0;
	logic                 in_taken = 1'b0;
	int unsigned          n_queued = 0;
	int unsigned          n_accepted = 0;
	int unsigned          n_checked = 0;
	int unsigned          n_short = 0;
	int unsigned          n_long = 0;
	int unsigned          n_settings = 1;
	int unsigned          n_errors = 0;

	function automatic logic [CountW-1:0] sat_step(input logic [CountW-1:0] v);
		return (v == '1) ? v : v + CountW'(1);
	endfunction

	// one millisecond tick of the classifier: counters first, then debounce, then long press
	function automatic logic [EventW-1:0] classify_tick(input logic level);
		logic [EventW-1:0] ev;
		ev = EV_NONE;
		if (pressing)
			press_ticks = sat_step(press_ticks);
		if (level != prev_raw)
			since_change = '0;
		else
			since_change = sat_step(since_change);
		// a level held strictly longer than the debounce time becomes the stable level
		if (since_change > db_ticks && level != stable_level) begin
			stable_level = level;
			if (!level) begin
				pressing    = 1'b1;
				press_ticks = '0;
				long_done   = 1'b0;
			end else begin
				pressing = 1'b0;
				// release after a long press stays silent
				if (!long_done && press_ticks > db_ticks)
					ev = EV_SHORT;
			end
		end
		// long press fires once, even on the accepting tick when the long time is zero
		if (pressing && !long_done && press_ticks >= long_ticks) begin
			long_done = 1'b1;
			ev        = EV_LONG;
		end
		prev_raw = level;
		return ev;
	endfunction

	function automatic logic idle_roll();
		return !no_idle && ($urandom_range(99, 0) < 27);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: inputs move on the falling edge only, a stalled request holds its level
	always @(negedge clk) begin
		out_stall <= idle_roll();
		if (!in_valid || in_taken) begin
			if (tick_levels.size() != 0 && !idle_roll()) begin
				in_valid     <= 1'b1;
				button_level <= tick_levels.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: register writes, accepted requests and results, all seen at the rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE:   db_ticks = cfg_data[DebounceW-1:0];
					REG_LONG_PRESS: long_ticks = cfg_data[CountW-1:0];
					default: ;
				endcase
			end
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				expected_events.push_back(classify_tick(button_level));
				n_accepted++;
			end
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					n_errors++;
					if (n_errors <= 20)
						$display("%0t: unexpected result, expected nothing, actual press_event %0d",
							$time, press_event);
				end else begin
					want_event = expected_events.pop_front();
					n_checked++;
					if (press_event !== want_event) begin
						n_errors++;
						if (n_errors <= 20)
							$display("%0t: press_event mismatch, expected %0d, actual %0d",
								$time, want_event, press_event);
					end
					if (want_event == EV_SHORT)
						n_short++;
					if (want_event == EV_LONG)
						n_long++;
				end
			end
		end
	end

	task automatic queue_run(input logic level, input int unsigned n);
		repeat (n) begin
			tick_levels.push_back(level);
			n_queued++;
		end
	endtask

	// wait until every request has gone in and every result has come back, then a little more
	task automatic drain();
		while (n_accepted != n_queued || expected_events.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_timing(input logic [CfgDataW-1:0] db_word,
		input logic [CfgDataW-1:0] lp_word);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_data  <= db_word;
		@(negedge clk);
		cfg_index <= REG_LONG_PRESS;
		cfg_data  <= lp_word;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		n_settings++;
	endtask

	// mostly clean presses around the thresholds, some bouncing and cut-short releases
	task automatic random_phase(input int unsigned n_items);
		int unsigned start;
		int unsigned kind;
		int unsigned dur;
		int unsigned db;
		int unsigned lp;
		start = n_queued;
		db    = db_ticks;
		lp    = long_ticks;
		while (n_queued - start < n_items) begin
			kind = $urandom_range(99, 0);
			if (kind < 15) begin
				dur = $urandom_range(4, 1);
				repeat (dur) queue_run(1'($urandom_range(1, 0)), 1);
			end else begin
				case ($urandom_range(2, 0))
					0: dur = db + $urandom_range(2, 0);
					1: dur = db + lp + $urandom_range(3, 0);
					default: dur = $urandom_range(2 * (db + lp) + 4, 1);
				endcase
				queue_run(1'b0, dur);
				if (kind < 25)
					queue_run(1'b1, $urandom_range(db + 1, 1));
				else
					queue_run(1'b1, db + $urandom_range(3, 1));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset timings: 50 ticks debounce, 5000 ticks to a long press
		queue_run(1'b1, 8);
		// bouncing contacts that never settle long enough
		queue_run(1'b0, 1);
		queue_run(1'b1, 1);
		queue_run(1'b0, 2);
		queue_run(1'b1, 4);
		// clean short press
		queue_run(1'b0, 70);
		queue_run(1'b1, 60);

		// zero debounce and zero long time, junk in the unused upper data bits
		set_timing(16'hFC00, 16'h0000);
		queue_run(1'b0, 3);
		queue_run(1'b1, 2);
		queue_run(1'b0, 1);
		queue_run(1'b1, 1);

		// long press, then a release that reports nothing, then a short one
		set_timing(16'h0004, 16'h0014);
		queue_run(1'b0, 40);
		queue_run(1'b1, 8);
		queue_run(1'b0, 14);
		queue_run(1'b1, 8);
		// press too brief to be accepted at this debounce
		queue_run(1'b0, 3);
		queue_run(1'b1, 6);

		set_timing(16'h0001, 16'h0001);
		queue_run(1'b0, 2);
		queue_run(1'b1, 2);
		queue_run(1'b0, 5);
		queue_run(1'b1, 3);

		// random part, small timings so presses stay short; one phase without any idling
		for (int ph = 0; ph < 5; ph++) begin
			set_timing({6'($urandom), 10'($urandom_range(6, 0))}, 16'($urandom_range(24, 0)));
			no_idle = (ph == 2);
			random_phase(90);
		end
		no_idle = 1'b0;

		drain();
		repeat (6) @(posedge clk);
		$display("checked %0d ticks over %0d timing settings", n_checked, n_settings);
		$display("seen %0d short and %0d long presses, %0d errors", n_short, n_long, n_errors);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#200_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== button_debounce_press_classifier.f =====
src/bdpc_pkg.sv
src/bdpc_cfg.sv
src/bdpc_core.sv
src/button_debounce_press_classifier.sv
verif/tb.sv
